FILE: design/nbt_pkg.sv
// Shared types, codes and constants of the NBT stream parser.
// No dependencies; every other design file imports this package.
package nbt_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int DEPTH_W   = 5;

    localparam logic [3:0] EV_HEADER    = 4'd0;
    localparam logic [3:0] EV_NAME      = 4'd1;
    localparam logic [3:0] EV_VALUE     = 4'd2;
    localparam logic [3:0] EV_STRING    = 4'd3;
    localparam logic [3:0] EV_ARR_START = 4'd4;
    localparam logic [3:0] EV_LST_START = 4'd5;
    localparam logic [3:0] EV_CMP_END   = 4'd6;
    localparam logic [3:0] EV_SEQ_END   = 4'd7;
    localparam logic [3:0] EV_DONE      = 4'd8;
    localparam logic [3:0] EV_ERROR     = 4'd9;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_END    = 3'd1;
    localparam logic [2:0] ERR_VARINT = 3'd2;
    localparam logic [2:0] ERR_NEG    = 3'd3;
    localparam logic [2:0] ERR_TYPE   = 3'd4;
    localparam logic [2:0] ERR_ROOT   = 3'd5;
    localparam logic [2:0] ERR_DEPTH  = 3'd6;

    localparam logic [3:0] TAG_END      = 4'd0;
    localparam logic [3:0] TAG_BYTE     = 4'd1;
    localparam logic [3:0] TAG_SHORT    = 4'd2;
    localparam logic [3:0] TAG_INT      = 4'd3;
    localparam logic [3:0] TAG_LONG     = 4'd4;
    localparam logic [3:0] TAG_FLOAT    = 4'd5;
    localparam logic [3:0] TAG_DOUBLE   = 4'd6;
    localparam logic [3:0] TAG_BARR     = 4'd7;
    localparam logic [3:0] TAG_STRING   = 4'd8;
    localparam logic [3:0] TAG_LIST     = 4'd9;
    localparam logic [3:0] TAG_COMPOUND = 4'd10;
    localparam logic [3:0] TAG_IARR     = 4'd11;
    localparam logic [3:0] TAG_LARR     = 4'd12;

    localparam logic [7:0] ROOT_BYTE = 8'd10;

    localparam logic [1:0] FR_COMPOUND = 2'd0;
    localparam logic [1:0] FR_LIST     = 2'd1;
    localparam logic [1:0] FR_ARRAY    = 2'd2;

    localparam logic [1:0] FIN_RUN  = 2'd0;
    localparam logic [1:0] FIN_DONE = 2'd1;
    localparam logic [1:0] FIN_ERR  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  ftype;
        logic [31:0] count;
    } frame_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [3:0]         ttype;
        logic [63:0]        val;
        logic [DEPTH_W-1:0] depth;
        logic [2:0]         code;
    } evt_t;

    typedef struct packed {
        logic emit;
        logic flush;
        evt_t evt;
    } evt_req_t;

    typedef struct packed {
        logic can_emit;
        logic flush_ok;
    } evt_stat_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        frame_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [3:0] {
        PH_ROOT, PH_NAME_LEN, PH_NAME, PH_TAG, PH_NUM, PH_STR_LEN, PH_STR,
        PH_LIST_TYPE, PH_LIST_LEN, PH_ARR_LEN, PH_HALT
    } phase_t;

    typedef enum logic [3:0] {
        C_IDLE, C_PROC, C_LEN2, C_BEGIN, C_FI, C_FI2, C_DONE, C_EOD, C_FLUSH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        NB_MORE, NB_DONE, NB_LONG
    } nb_res_t;

    function automatic logic [3:0] array_elem(input logic [3:0] t);
        if (t == TAG_BARR) begin
            return TAG_BYTE;
        end else if (t == TAG_IARR) begin
            return TAG_INT;
        end
        return TAG_LONG;
    endfunction

    function automatic evt_t mk_evt(input logic [3:0] kind, input logic [3:0] ttype,
                                    input logic [63:0] val,
                                    input logic [LVL_W-1:0] level,
                                    input logic [2:0] code);
        evt_t e;
        e.kind  = kind;
        e.ttype = ttype;
        e.val   = val;
        e.depth = DEPTH_W'(level);
        e.code  = code;
        return e;
    endfunction

endpackage

FILE: design/nbt_stream_parser.sv
// NBT stream parser top level: format register, sequencer, frame stack, output.
// Depends on nbt_pkg, nbt_frame_ram, nbt_evt_out and nbt_parse_ctrl.
//
// Takes one NBT byte per transfer and returns its events, the last one of each byte
// flagged by m_last_in_run. A plain byte passes through the accept, decode, end-of-data
// and flush states before the next ready; starting a nested item adds C_BEGIN, with
// C_LEN2 before it for a list or array, and each stack frame visited when an item
// completes adds C_FI and C_FI2: a registered read of the frame memory, then its count
// is updated and written back. Closing the root compound adds the C_DONE state for the
// done event; the end-of-data error is raised in the C_EOD state and adds none. A stalled
// m_ready holds the sequencer once one event is held beside the output register. The user
// must write stream_format only while the block is idle; the block does not enforce it.
module nbt_stream_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    input  logic               s_end_of_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_event_kind,
    output logic [3:0]         m_tag_type,
    output logic signed [63:0] m_value,
    output logic [4:0]         m_depth,
    output logic [2:0]         m_error_code,
    output logic               m_last_in_run
);
    import nbt_pkg::*;

    logic      fmt_reg;
    evt_req_t  evt_req;
    evt_stat_t evt_stat;
    ram_req_t  ram_req;
    frame_t    ram_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            fmt_reg <= cfg_wr_data;
        end
    end

    nbt_parse_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stream_format (fmt_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_data (s_end_of_data),
        .stat          (evt_stat),
        .req           (evt_req),
        .ram           (ram_req),
        .rd_data       (ram_rd)
    );

    nbt_frame_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd)
    );

    nbt_evt_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req           (evt_req),
        .stat          (evt_stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_tag_type    (m_tag_type),
        .m_value       (m_value),
        .m_depth       (m_depth),
        .m_error_code  (m_error_code),
        .m_last_in_run (m_last_in_run)
    );

endmodule

FILE: design/nbt_frame_ram.sv
// Frame stack storage: one write port, one registered read port.
// Depends on nbt_pkg for the frame type and address width.
module nbt_frame_ram (
    input  logic              aclk,
    input  nbt_pkg::ram_req_t req,
    output nbt_pkg::frame_t   rd_data
);
    import nbt_pkg::*;

    frame_t mem [MAX_DEPTH];
    frame_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/nbt_evt_out.sv
// Result staging: a one-deep hold slot and the output register.
// Marks the last transfer of a byte on flush. Depends on nbt_pkg.
module nbt_evt_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  nbt_pkg::evt_req_t   req,
    output nbt_pkg::evt_stat_t  stat,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_event_kind,
    output logic [3:0]          m_tag_type,
    output logic signed [63:0]  m_value,
    output logic [4:0]          m_depth,
    output logic [2:0]          m_error_code,
    output logic                m_last_in_run
);
    import nbt_pkg::*;

    evt_t pend_reg, pend_next;
    logic pend_v_reg, pend_v_next;
    evt_t out_reg, out_next;
    logic out_last_reg, out_last_next;
    logic out_v_reg, out_v_next;
    logic out_free;

    assign out_free      = !out_v_reg || m_ready;
    assign stat.can_emit = !pend_v_reg || out_free;
    assign stat.flush_ok = !pend_v_reg || out_free;

    always_comb begin
        pend_next     = pend_reg;
        pend_v_next   = pend_v_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_v_next    = out_v_reg;
        if (out_v_reg && m_ready) begin
            out_v_next = 1'b0;
        end
        if (req.emit && stat.can_emit) begin
            if (pend_v_reg) begin
                out_next      = pend_reg;
                out_last_next = 1'b0;
                out_v_next    = 1'b1;
            end
            pend_next   = req.evt;
            pend_v_next = 1'b1;
        end else if (req.flush && pend_v_reg && out_free) begin
            out_next      = pend_reg;
            out_last_next = 1'b1;
            out_v_next    = 1'b1;
            pend_v_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid       = out_v_reg;
    assign m_event_kind  = out_reg.kind;
    assign m_tag_type    = out_reg.ttype;
    assign m_value       = out_reg.val;
    assign m_depth       = out_reg.depth;
    assign m_error_code  = out_reg.code;
    assign m_last_in_run = out_last_reg;

endmodule

FILE: design/nbt_parse_ctrl.sv
// Parse sequencer: byte decoding, number assembly and frame stack
// read-modify-write. Depends on nbt_pkg; drives nbt_frame_ram and nbt_evt_out.
module nbt_parse_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               stream_format,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    input  logic               s_end_of_data,
    input  nbt_pkg::evt_stat_t stat,
    output nbt_pkg::evt_req_t  req,
    output nbt_pkg::ram_req_t  ram,
    input  nbt_pkg::frame_t    rd_data
);
    import nbt_pkg::*;

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  fi_reg, fi_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] left_reg, left_next;
    logic [3:0]  pend_reg, pend_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [1:0]  fin_reg, fin_next;
    logic [7:0]  b_reg, b_next;
    logic        eod_reg, eod_next;
    logic [3:0]  item_reg, item_next;
    logic        lzero_reg, lzero_next;

    logic [3:0]  nb_type, fi_inc, nb_len, tt;
    logic        nb_var, is_list;
    logic [6:0]  shamt7;
    logic [63:0] acc_new, num_val;
    nb_res_t     nb_res;
    logic [31:0] len8, zz32, left_dec, cnt_dec;
    logic        go;

    assign go      = stat.can_emit;
    assign s_ready = (state_reg == C_IDLE);
    assign tt      = (b_reg > 8'd15) ? 4'd15 : b_reg[3:0];
    assign is_list = (phase_reg == PH_LIST_LEN);
    assign left_dec = (left_reg != 32'd0) ? left_reg - 32'd1 : 32'd0;
    assign cnt_dec  = (rd_data.count != 32'd0) ? rd_data.count - 32'd1 : 32'd0;

    always_comb begin
        if (phase_reg == PH_NUM) begin
            nb_type = pend_reg;
        end else if (phase_reg == PH_LIST_LEN || phase_reg == PH_ARR_LEN) begin
            nb_type = TAG_INT;
        end else begin
            nb_type = TAG_STRING;
        end
        nb_var = stream_format &&
                 (nb_type == TAG_INT || nb_type == TAG_LONG || nb_type == TAG_STRING);
        fi_inc  = fi_reg + 4'd1;
        shamt7  = {fi_reg, 3'b000} - {3'b000, fi_reg};
        acc_new = acc_reg;
        nb_len  = 4'd8;
        if (nb_var) begin
            if (fi_reg <= 4'd9) begin
                acc_new = acc_reg | ({57'd0, b_reg[6:0]} << shamt7);
            end
            if (!b_reg[7]) begin
                nb_res = NB_DONE;
            end else if (fi_inc >= ((nb_type == TAG_LONG) ? 4'd10 : 4'd5)) begin
                nb_res = NB_LONG;
            end else begin
                nb_res = NB_MORE;
            end
        end else begin
            if (!fi_reg[3]) begin
                acc_new = acc_reg | ({56'd0, b_reg} << {fi_reg[2:0], 3'b000});
            end
            case (nb_type)
                TAG_BYTE: begin
                    nb_len = 4'd1;
                end
                TAG_SHORT, TAG_STRING: begin
                    nb_len = 4'd2;
                end
                TAG_INT, TAG_FLOAT: begin
                    nb_len = 4'd4;
                end
                default: begin
                    nb_len = 4'd8;
                end
            endcase
            nb_res = (fi_inc >= nb_len) ? NB_DONE : NB_MORE;
        end

        len8 = nb_var ? acc_new[31:0] : {16'd0, acc_new[15:0]};
        zz32 = nb_var ? ((acc_new[31:0] >> 1) ^ {32{acc_new[0]}}) : acc_new[31:0];

        if (nb_var && nb_type == TAG_LONG) begin
            num_val = (acc_new >> 1) ^ {64{acc_new[0]}};
        end else begin
            case (nb_type)
                TAG_BYTE: begin
                    num_val = {{56{acc_new[7]}}, acc_new[7:0]};
                end
                TAG_SHORT: begin
                    num_val = {{48{acc_new[15]}}, acc_new[15:0]};
                end
                TAG_INT: begin
                    num_val = {{32{zz32[31]}}, zz32};
                end
                TAG_FLOAT: begin
                    num_val = {32'd0, acc_new[31:0]};
                end
                default: begin
                    num_val = acc_new;
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        fi_next    = fi_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        pend_next  = pend_reg;
        level_next = level_reg;
        fin_next   = fin_reg;
        b_next     = b_reg;
        eod_next   = eod_reg;
        item_next  = item_reg;
        lzero_next = lzero_reg;
        req        = '0;
        ram        = '0;

        case (state_reg)
            C_IDLE: begin
                if (s_valid) begin
                    b_next     = s_in_byte;
                    eod_next   = s_end_of_data;
                    state_next = (fin_reg == FIN_RUN) ? C_PROC : C_EOD;
                end
            end

            C_PROC: begin
                if (go) begin
                    state_next = C_EOD;
                    case (phase_reg)
                        PH_ROOT: begin
                            req.emit = 1'b1;
                            if (b_reg != ROOT_BYTE) begin
                                req.evt = mk_evt(EV_ERROR, TAG_END, 64'd0, level_reg, ERR_ROOT);
                                fin_next   = FIN_ERR;
                                phase_next = PH_HALT;
                            end else begin
                                req.evt = mk_evt(EV_HEADER, TAG_COMPOUND, {56'd0, b_reg},
                                                 level_reg, ERR_NONE);
                                pend_next  = TAG_COMPOUND;
                                phase_next = PH_NAME_LEN;
                                fi_next    = 4'd0;
                                acc_next   = 64'd0;
                            end
                        end
                        PH_NAME_LEN, PH_STR_LEN: begin
                            fi_next  = fi_inc;
                            acc_next = acc_new;
                            if (nb_res == NB_LONG) begin
                                req.emit = 1'b1;
                                req.evt  = mk_evt(EV_ERROR, TAG_END, 64'd0, level_reg,
                                                  ERR_VARINT);
                                fin_next   = FIN_ERR;
                                phase_next = PH_HALT;
                            end else if (nb_res == NB_DONE) begin
                                left_next = len8;
                                if (phase_reg == PH_NAME_LEN) begin
                                    if (len8 == 32'd0) begin
                                        item_next  = (level_reg == '0) ? TAG_COMPOUND : pend_reg;
                                        state_next = C_BEGIN;
                                    end else begin
                                        phase_next = PH_NAME;
                                    end
                                end else begin
                                    req.emit = 1'b1;
                                    req.evt  = mk_evt(EV_VALUE, TAG_STRING, {32'd0, len8},
                                                      level_reg, ERR_NONE);
                                    if (len8 == 32'd0) begin
                                        state_next = C_FI;
                                    end else begin
                                        phase_next = PH_STR;
                                    end
                                end
                            end
                        end
                        PH_NAME: begin
                            req.emit  = 1'b1;
                            req.evt   = mk_evt(EV_NAME, pend_reg, {56'd0, b_reg}, level_reg,
                                               ERR_NONE);
                            left_next = left_dec;
                            if (left_dec == 32'd0) begin
                                item_next  = (level_reg == '0) ? TAG_COMPOUND : pend_reg;
                                state_next = C_BEGIN;
                            end
                        end
                        PH_STR: begin
                            req.emit  = 1'b1;
                            req.evt   = mk_evt(EV_STRING, TAG_STRING, {56'd0, b_reg},
                                               level_reg, ERR_NONE);
                            left_next = left_dec;
                            if (left_dec == 32'd0) begin
                                state_next = C_FI;
                            end
                        end
                        PH_TAG: begin
                            req.emit = 1'b1;
                            if (b_reg == 8'd0) begin
                                if (level_reg != '0) begin
                                    level_next = level_reg - LVL_W'(1);
                                end
                                req.evt = mk_evt(EV_CMP_END, TAG_COMPOUND, 64'd0, level_next,
                                                 ERR_NONE);
                                state_next = (level_next == '0) ? C_DONE : C_FI;
                            end else begin
                                req.evt = mk_evt(EV_HEADER, tt, {56'd0, b_reg}, level_reg,
                                                 ERR_NONE);
                                pend_next  = tt;
                                phase_next = PH_NAME_LEN;
                                fi_next    = 4'd0;
                                acc_next   = 64'd0;
                            end
                        end
                        PH_NUM: begin
                            fi_next  = fi_inc;
                            acc_next = acc_new;
                            if (nb_res == NB_LONG) begin
                                req.emit = 1'b1;
                                req.evt  = mk_evt(EV_ERROR, TAG_END, 64'd0, level_reg,
                                                  ERR_VARINT);
                                fin_next   = FIN_ERR;
                                phase_next = PH_HALT;
                            end else if (nb_res == NB_DONE) begin
                                req.emit   = 1'b1;
                                req.evt    = mk_evt(EV_VALUE, pend_reg, num_val, level_reg,
                                                    ERR_NONE);
                                state_next = C_FI;
                            end
                        end
                        PH_LIST_TYPE: begin
                            pend_next  = tt;
                            phase_next = PH_LIST_LEN;
                            fi_next    = 4'd0;
                            acc_next   = 64'd0;
                        end
                        PH_LIST_LEN, PH_ARR_LEN: begin
                            fi_next  = fi_inc;
                            acc_next = acc_new;
                            if (nb_res == NB_LONG) begin
                                req.emit = 1'b1;
                                req.evt  = mk_evt(EV_ERROR, TAG_END, 64'd0, level_reg,
                                                  ERR_VARINT);
                                fin_next   = FIN_ERR;
                                phase_next = PH_HALT;
                            end else if (nb_res == NB_DONE) begin
                                req.emit = 1'b1;
                                if (zz32[31]) begin
                                    req.evt = mk_evt(EV_ERROR, TAG_END, 64'd0, level_reg,
                                                     ERR_NEG);
                                    fin_next   = FIN_ERR;
                                    phase_next = PH_HALT;
                                end else begin
                                    req.evt = mk_evt(is_list ? EV_LST_START : EV_ARR_START,
                                                     pend_reg, {32'd0, zz32}, level_reg,
                                                     ERR_NONE);
                                    left_next  = zz32;
                                    lzero_next = (zz32 == 32'd0);
                                    state_next = C_LEN2;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            C_LEN2: begin
                if (go) begin
                    if (lzero_reg || (is_list && pend_reg == TAG_END)) begin
                        req.emit   = 1'b1;
                        req.evt    = mk_evt(EV_SEQ_END, pend_reg, 64'd0, level_reg, ERR_NONE);
                        state_next = C_FI;
                    end else if (level_reg >= LVL_W'(MAX_DEPTH)) begin
                        req.emit   = 1'b1;
                        req.evt    = mk_evt(EV_ERROR, TAG_END, 64'd0, level_reg, ERR_DEPTH);
                        fin_next   = FIN_ERR;
                        phase_next = PH_HALT;
                        state_next = C_EOD;
                    end else begin
                        ram.we          = 1'b1;
                        ram.waddr       = level_reg[ADDR_W-1:0];
                        ram.wdata.kind  = is_list ? FR_LIST : FR_ARRAY;
                        ram.wdata.ftype = pend_reg;
                        ram.wdata.count = left_reg;
                        level_next      = level_reg + LVL_W'(1);
                        item_next       = is_list ? pend_reg : array_elem(pend_reg);
                        state_next      = C_BEGIN;
                    end
                end
            end

            C_BEGIN: begin
                if (go) begin
                    state_next = C_EOD;
                    if (item_reg >= TAG_BYTE && item_reg <= TAG_DOUBLE) begin
                        pend_next  = item_reg;
                        phase_next = PH_NUM;
                        fi_next    = 4'd0;
                        acc_next   = 64'd0;
                    end else if (item_reg == TAG_BARR || item_reg == TAG_IARR ||
                                 item_reg == TAG_LARR) begin
                        pend_next  = item_reg;
                        phase_next = PH_ARR_LEN;
                        fi_next    = 4'd0;
                        acc_next   = 64'd0;
                    end else if (item_reg == TAG_STRING) begin
                        phase_next = PH_STR_LEN;
                        fi_next    = 4'd0;
                        acc_next   = 64'd0;
                    end else if (item_reg == TAG_LIST) begin
                        phase_next = PH_LIST_TYPE;
                    end else if (item_reg == TAG_COMPOUND) begin
                        if (level_reg >= LVL_W'(MAX_DEPTH)) begin
                            req.emit   = 1'b1;
                            req.evt    = mk_evt(EV_ERROR, TAG_END, 64'd0, level_reg,
                                                ERR_DEPTH);
                            fin_next   = FIN_ERR;
                            phase_next = PH_HALT;
                        end else begin
                            ram.we          = 1'b1;
                            ram.waddr       = level_reg[ADDR_W-1:0];
                            ram.wdata.kind  = FR_COMPOUND;
                            ram.wdata.ftype = TAG_COMPOUND;
                            ram.wdata.count = 32'd0;
                            level_next      = level_reg + LVL_W'(1);
                            phase_next      = PH_TAG;
                        end
                    end else begin
                        req.emit   = 1'b1;
                        req.evt    = mk_evt(EV_ERROR, TAG_END, 64'd0, level_reg, ERR_TYPE);
                        fin_next   = FIN_ERR;
                        phase_next = PH_HALT;
                    end
                end
            end

            C_FI: begin
                if (fin_reg != FIN_RUN || level_reg == '0) begin
                    state_next = C_EOD;
                end else begin
                    ram.re     = 1'b1;
                    ram.raddr  = ADDR_W'(level_reg - LVL_W'(1));
                    state_next = C_FI2;
                end
            end

            C_FI2: begin
                if (go) begin
                    if (rd_data.kind == FR_COMPOUND) begin
                        phase_next = PH_TAG;
                        state_next = C_EOD;
                    end else if (cnt_dec != 32'd0) begin
                        ram.we          = 1'b1;
                        ram.waddr       = ADDR_W'(level_reg - LVL_W'(1));
                        ram.wdata       = rd_data;
                        ram.wdata.count = cnt_dec;
                        item_next       = (rd_data.kind == FR_LIST) ? rd_data.ftype
                                                                    : array_elem(rd_data.ftype);
                        state_next      = C_BEGIN;
                    end else begin
                        level_next = level_reg - LVL_W'(1);
                        req.emit   = 1'b1;
                        req.evt    = mk_evt(EV_SEQ_END, rd_data.ftype, 64'd0, level_next,
                                            ERR_NONE);
                        state_next = C_FI;
                    end
                end
            end

            C_DONE: begin
                if (go) begin
                    req.emit   = 1'b1;
                    req.evt    = mk_evt(EV_DONE, TAG_END, 64'd0, level_reg, ERR_NONE);
                    fin_next   = FIN_DONE;
                    phase_next = PH_HALT;
                    state_next = C_EOD;
                end
            end

            C_EOD: begin
                if (go) begin
                    if (eod_reg) begin
                        if (fin_reg == FIN_RUN) begin
                            req.emit = 1'b1;
                            req.evt  = mk_evt(EV_ERROR, TAG_END, 64'd0, level_reg, ERR_END);
                        end
                        phase_next = PH_ROOT;
                        fi_next    = 4'd0;
                        acc_next   = 64'd0;
                        left_next  = 32'd0;
                        pend_next  = TAG_END;
                        level_next = '0;
                        fin_next   = FIN_RUN;
                    end
                    state_next = C_FLUSH;
                end
            end

            C_FLUSH: begin
                req.flush = 1'b1;
                if (stat.flush_ok) begin
                    state_next = C_IDLE;
                end
            end

            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            phase_reg <= PH_ROOT;
            fi_reg    <= 4'd0;
            acc_reg   <= 64'd0;
            left_reg  <= 32'd0;
            pend_reg  <= TAG_END;
            level_reg <= '0;
            fin_reg   <= FIN_RUN;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            fi_reg    <= fi_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
            level_reg <= level_next;
            fin_reg   <= fin_next;
        end
        b_reg     <= b_next;
        eod_reg   <= eod_next;
        item_reg  <= item_next;
        lzero_reg <= lzero_next;
    end

endmodule

FILE: test/testbench.sv
// Self-checking testbench for nbt_stream_parser: directed buffers in both formats,
// then random NBT trees with broken variants, under random gaps and output stalls.
// Depends on nbt_pkg and the nbt_stream_parser RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nbt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RUN_CAP     = 18;
    localparam int SETTLE      = 100;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  ttype;
        logic [63:0] val;
        logic [4:0]  depth;
        logic [2:0]  code;
        logic        last;
    } nbt_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'd0;
    logic        s_end_of_data = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_event_kind;
    logic [3:0]  m_tag_type;
    logic signed [63:0] m_value;
    logic [4:0]  m_depth;
    logic [2:0]  m_error_code;
    logic        m_last_in_run;

    nbt_stream_parser u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_end_of_data(s_end_of_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_kind (m_event_kind),
        .m_tag_type   (m_tag_type),
        .m_value      (m_value),
        .m_depth      (m_depth),
        .m_error_code (m_error_code),
        .m_last_in_run(m_last_in_run)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nbt_event_t  expected_events[$];
    nbt_event_t  run_events[$];
    logic [7:0]  byte_q[$];
    int          error_count = 0;
    int          live_bytes = 0;
    int          bytes_sent = 0;
    int          events_seen = 0;
    int          buffers_sent = 0;
    int          cycle_count = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int          stall_left = 0;

    // parser mirror
    bit          p_fmt;
    phase_t      p_phase;
    logic [3:0]  p_fidx;
    logic [63:0] p_acc;
    logic [31:0] p_left;
    logic [3:0]  p_ptype;
    logic [1:0]  fr_kind[MAX_DEPTH];
    logic [3:0]  fr_type[MAX_DEPTH];
    logic [31:0] fr_cnt[MAX_DEPTH];
    int          p_lvl;
    logic [1:0]  p_fin;

    task automatic add_byte(input logic [7:0] b);
        byte_q.insert(byte_q.size(), b);
    endtask

    task automatic rearm_mirror();
        p_phase = PH_ROOT;
        p_fidx  = '0;
        p_acc   = '0;
        p_left  = '0;
        p_ptype = '0;
        p_lvl   = 0;
        p_fin   = FIN_RUN;
    endtask

    task automatic emit_ev(input logic [3:0] k, input logic [3:0] t, input logic [63:0] v,
                           input logic [2:0] c);
        nbt_event_t e;
        if (run_events.size() >= RUN_CAP) return;
        e.kind  = k;
        e.ttype = t;
        e.val   = v;
        e.depth = 5'(p_lvl);
        e.code  = c;
        e.last  = 1'b0;
        run_events.insert(run_events.size(), e);
    endtask

    task automatic abort_parse(input logic [2:0] c);
        emit_ev(EV_ERROR, TAG_END, 64'd0, c);
        p_fin   = FIN_ERR;
        p_phase = PH_HALT;
    endtask

    task automatic restart_num(input phase_t ph);
        p_phase = ph;
        p_fidx  = '0;
        p_acc   = '0;
    endtask

    function automatic bit is_varint(input logic [3:0] t);
        return p_fmt && (t == TAG_INT || t == TAG_LONG || t == TAG_STRING);
    endfunction

    // 0 more bytes needed, 1 complete, 2 VarInt too long
    task automatic take_num_byte(input logic [3:0] t, input logic [7:0] b, output int res);
        int limit;
        int shift;
        int n;
        if (is_varint(t)) begin
            limit = (t == TAG_LONG) ? 70 : 35;
            shift = 7 * p_fidx;
            if (shift < 64) p_acc = p_acc | (64'(b & 8'h7F) << shift);
            p_fidx = p_fidx + 4'd1;
            if (!b[7]) res = 1;
            else if (7 * int'(p_fidx) >= limit) res = 2;
            else res = 0;
            return;
        end
        case (t)
            TAG_BYTE: n = 1;
            TAG_SHORT, TAG_STRING: n = 2;
            TAG_INT, TAG_FLOAT: n = 4;
            default: n = 8;
        endcase
        if (p_fidx < 8) p_acc = p_acc | (64'(b) << (8 * p_fidx));
        p_fidx = p_fidx + 4'd1;
        res = (int'(p_fidx) >= n) ? 1 : 0;
    endtask

    function automatic logic [63:0] decode_num(input logic [3:0] t);
        logic [63:0] a;
        logic [31:0] r;
        a = p_acc;
        if (is_varint(t)) begin
            if (t == TAG_STRING) return {32'd0, a[31:0]};
            if (t == TAG_INT) begin
                r = (a[31:0] >> 1) ^ {32{a[0]}};
                return {{32{r[31]}}, r};
            end
            return (a >> 1) ^ {64{a[0]}};
        end
        case (t)
            TAG_BYTE:   return {{56{a[7]}}, a[7:0]};
            TAG_SHORT:  return {{48{a[15]}}, a[15:0]};
            TAG_INT:    return {{32{a[31]}}, a[31:0]};
            TAG_FLOAT:  return {32'd0, a[31:0]};
            TAG_STRING: return {48'd0, a[15:0]};
            default:    return a;
        endcase
    endfunction

    task automatic push_frame(input logic [1:0] k, input logic [3:0] t, input logic [31:0] n,
                              output bit ok);
        if (p_lvl >= MAX_DEPTH) begin
            abort_parse(ERR_DEPTH);
            ok = 1'b0;
            return;
        end
        fr_kind[p_lvl] = k;
        fr_type[p_lvl] = t;
        fr_cnt[p_lvl]  = n;
        p_lvl++;
        ok = 1'b1;
    endtask

    function automatic logic [3:0] elem_of(input logic [3:0] t);
        return t == TAG_BARR ? TAG_BYTE : (t == TAG_IARR ? TAG_INT : TAG_LONG);
    endfunction

    task automatic open_item(input logic [3:0] t);
        bit ok;
        case (t)
            TAG_BYTE, TAG_SHORT, TAG_INT, TAG_LONG, TAG_FLOAT, TAG_DOUBLE: begin
                p_ptype = t;
                restart_num(PH_NUM);
            end
            TAG_BARR, TAG_IARR, TAG_LARR: begin
                p_ptype = t;
                restart_num(PH_ARR_LEN);
            end
            TAG_STRING: restart_num(PH_STR_LEN);
            TAG_LIST: p_phase = PH_LIST_TYPE;
            TAG_COMPOUND: begin
                push_frame(FR_COMPOUND, TAG_COMPOUND, 32'd0, ok);
                if (ok) p_phase = PH_TAG;
            end
            default: abort_parse(ERR_TYPE);
        endcase
    endtask

    // close completed frames up the stack
    task automatic close_item();
        logic [3:0] ty;
        while (p_fin == FIN_RUN && p_lvl > 0) begin
            if (fr_kind[p_lvl-1] == FR_COMPOUND) begin
                p_phase = PH_TAG;
                return;
            end
            if (fr_cnt[p_lvl-1] != 0) fr_cnt[p_lvl-1]--;
            if (fr_cnt[p_lvl-1] != 0) begin
                open_item(fr_kind[p_lvl-1] == FR_LIST ? fr_type[p_lvl-1]
                                                      : elem_of(fr_type[p_lvl-1]));
                return;
            end
            ty = fr_type[p_lvl-1];
            p_lvl--;
            emit_ev(EV_SEQ_END, ty, 64'd0, ERR_NONE);
        end
    endtask

    task automatic name_finished();
        bit ok;
        if (p_lvl == 0) begin
            push_frame(FR_COMPOUND, TAG_COMPOUND, 32'd0, ok);
            if (ok) p_phase = PH_TAG;
        end else begin
            open_item(p_ptype);
        end
    endtask

    task automatic length_finished();
        logic [63:0] n;
        logic [3:0]  t;
        bit          ok;
        n = decode_num(TAG_INT);
        t = p_ptype;
        if (n[63]) begin
            abort_parse(ERR_NEG);
            return;
        end
        if (p_phase == PH_LIST_LEN) begin
            emit_ev(EV_LST_START, t, n, ERR_NONE);
            if (n == 0 || t == TAG_END) begin
                emit_ev(EV_SEQ_END, t, 64'd0, ERR_NONE);
                close_item();
            end else begin
                push_frame(FR_LIST, t, n[31:0], ok);
                if (ok) open_item(t);
            end
        end else begin
            emit_ev(EV_ARR_START, t, n, ERR_NONE);
            if (n == 0) begin
                emit_ev(EV_SEQ_END, t, 64'd0, ERR_NONE);
                close_item();
            end else begin
                push_frame(FR_ARRAY, t, n[31:0], ok);
                if (ok) open_item(elem_of(t));
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        int         r;
        logic [3:0] tt;
        tt = (b > 8'd15) ? 4'd15 : b[3:0];
        case (p_phase)
            PH_ROOT: begin
                if (b != ROOT_BYTE) begin
                    abort_parse(ERR_ROOT);
                end else begin
                    emit_ev(EV_HEADER, TAG_COMPOUND, 64'(b), ERR_NONE);
                    p_ptype = TAG_COMPOUND;
                    restart_num(PH_NAME_LEN);
                end
            end
            PH_NAME_LEN, PH_STR_LEN: begin
                take_num_byte(TAG_STRING, b, r);
                if (r == 2) begin
                    abort_parse(ERR_VARINT);
                end else if (r == 1) begin
                    p_left = 32'(decode_num(TAG_STRING));
                    if (p_phase == PH_NAME_LEN) begin
                        if (p_left == 0) name_finished();
                        else p_phase = PH_NAME;
                    end else begin
                        emit_ev(EV_VALUE, TAG_STRING, 64'(p_left), ERR_NONE);
                        if (p_left == 0) close_item();
                        else p_phase = PH_STR;
                    end
                end
            end
            PH_NAME: begin
                emit_ev(EV_NAME, p_ptype, 64'(b), ERR_NONE);
                if (p_left != 0) p_left--;
                if (p_left == 0) name_finished();
            end
            PH_STR: begin
                emit_ev(EV_STRING, TAG_STRING, 64'(b), ERR_NONE);
                if (p_left != 0) p_left--;
                if (p_left == 0) close_item();
            end
            PH_TAG: begin
                if (b == 8'd0) begin
                    if (p_lvl > 0) p_lvl--;
                    emit_ev(EV_CMP_END, TAG_COMPOUND, 64'd0, ERR_NONE);
                    if (p_lvl == 0) begin
                        emit_ev(EV_DONE, TAG_END, 64'd0, ERR_NONE);
                        p_fin   = FIN_DONE;
                        p_phase = PH_HALT;
                    end else begin
                        close_item();
                    end
                end else begin
                    emit_ev(EV_HEADER, tt, 64'(b), ERR_NONE);
                    p_ptype = tt;
                    restart_num(PH_NAME_LEN);
                end
            end
            PH_NUM: begin
                take_num_byte(p_ptype, b, r);
                if (r == 2) begin
                    abort_parse(ERR_VARINT);
                end else if (r == 1) begin
                    emit_ev(EV_VALUE, p_ptype, decode_num(p_ptype), ERR_NONE);
                    close_item();
                end
            end
            PH_LIST_TYPE: begin
                p_ptype = tt;
                restart_num(PH_LIST_LEN);
            end
            PH_LIST_LEN, PH_ARR_LEN: begin
                take_num_byte(TAG_INT, b, r);
                if (r == 2) abort_parse(ERR_VARINT);
                else if (r == 1) length_finished();
            end
            default: ;
        endcase
    endtask

    task automatic predict_events(input logic [7:0] b, input logic eod);
        nbt_event_t e;
        run_events.delete();
        if (p_fin == FIN_RUN) begin
            live_bytes++;
            parse_byte(b);
        end
        if (eod) begin
            if (p_fin == FIN_RUN) abort_parse(ERR_END);
            rearm_mirror();
        end
        if (run_events.size() > 0) begin
            e = run_events.pop_back();
            e.last = 1'b1;
            run_events.insert(run_events.size(), e);
        end
        foreach (run_events[i]) expected_events.insert(expected_events.size(), run_events[i]);
    endtask

    // random idle lengths: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eod);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_byte     <= b;
        s_end_of_data <= eod;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        predict_events(b, eod);
    endtask

    task automatic send_buffer();
        foreach (byte_q[i]) send_byte(byte_q[i], i == byte_q.size() - 1);
        buffers_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_format(input bit f);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= f;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        p_fmt = f;
    endtask

    // encoders for the generated buffers
    task automatic put_varint(input logic [63:0] v);
        logic [7:0] b;
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0) b[7] = 1'b1;
            add_byte(b);
        end while (v != 0);
    endtask

    task automatic put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
    endtask

    task automatic put_len(input int n);
        if (p_fmt) put_varint(64'(n));
        else put_le(64'(n), 2);
    endtask

    task automatic put_count(input logic [31:0] n);
        if (p_fmt) put_varint({32'd0, (n << 1) ^ {32{n[31]}}});
        else put_le(64'(n), 4);
    endtask

    task automatic put_name();
        int n;
        n = $urandom_range(0, 3);
        put_len(n);
        repeat (n) add_byte(8'($urandom));
    endtask

    task automatic put_prim(input logic [3:0] t);
        logic [63:0] v;
        int          n;
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 3) == 0) v = ~v;
        case (t)
            TAG_BYTE:   put_le(v, 1);
            TAG_SHORT:  put_le(v, 2);
            TAG_FLOAT:  put_le(v, 4);
            TAG_DOUBLE: put_le(v, 8);
            TAG_INT: begin
                if (p_fmt) put_count(v[31:0]);
                else put_le(v, 4);
            end
            TAG_LONG: begin
                if (p_fmt) put_varint((v << 1) ^ {64{v[63]}});
                else put_le(v, 8);
            end
            TAG_STRING: begin
                n = $urandom_range(0, 4);
                put_len(n);
                repeat (n) add_byte(8'($urandom));
            end
            default: begin
                n = $urandom_range(0, 3);
                put_count(32'(n));
                repeat (n) put_prim(elem_of(t));
            end
        endcase
    endtask

    function automatic logic [3:0] pick_prim();
        logic [3:0] t;
        t = 4'($urandom_range(1, 10));
        if (t == TAG_LIST) t = TAG_IARR;
        if (t == TAG_COMPOUND) t = TAG_LARR;
        return t;
    endfunction

    task automatic put_leaf(input logic [3:0] t);
        logic [3:0] et;
        int         n;
        if (t == TAG_LIST) begin
            et = pick_prim();
            n  = $urandom_range(0, 3);
            add_byte(8'(et));
            put_count(32'(n));
            repeat (n) put_prim(et);
        end else if (t == TAG_COMPOUND) begin
            repeat ($urandom_range(0, 2)) begin
                et = pick_prim();
                add_byte(8'(et));
                put_name();
                put_prim(et);
            end
            add_byte(8'd0);
        end else begin
            put_prim(t);
        end
    endtask

    task automatic put_value(input logic [3:0] t);
        logic [3:0] et;
        int         n;
        if (t == TAG_LIST) begin
            et = 4'($urandom_range(0, 12));
            n  = $urandom_range(0, 3);
            add_byte(8'(et));
            put_count(32'(n));
            if (et != TAG_END) repeat (n) put_leaf(et);
        end else if (t == TAG_COMPOUND) begin
            repeat ($urandom_range(0, 3)) begin
                et = 4'($urandom_range(1, 12));
                add_byte(8'(et));
                put_name();
                put_leaf(et);
            end
            add_byte(8'd0);
        end else begin
            put_prim(t);
        end
    endtask

    task automatic build_tree();
        logic [3:0] et;
        byte_q.delete();
        add_byte(ROOT_BYTE);
        put_name();
        repeat ($urandom_range(1, 4)) begin
            et = 4'($urandom_range(1, 12));
            add_byte(8'(et));
            put_name();
            put_value(et);
        end
        add_byte(8'd0);
    endtask

    // checking of every result transfer
    always @(posedge aclk) begin
        nbt_event_t got;
        nbt_event_t want;
        if (aresetn && m_valid && m_ready) begin
            events_seen++;
            got = {m_event_kind, m_tag_type, m_value, m_depth, m_error_code, m_last_in_run};
            if (expected_events.size() == 0) begin
                error_count++;
                $display("%0t: expected none, actual k=%0d t=%0d v=%h d=%0d c=%0d l=%0b",
                         $time, got.kind, got.ttype, got.val, got.depth, got.code, got.last);
            end else begin
                want = expected_events.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: expected k=%0d t=%0d v=%h d=%0d c=%0d l=%0b",
                             $time, want.kind, want.ttype, want.val, want.depth, want.code,
                             want.last);
                    $display("%0t: actual   k=%0d t=%0d v=%h d=%0d c=%0d l=%0b",
                             $time, got.kind, got.ttype, got.val, got.depth, got.code,
                             got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!stalls_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 9) < 7) begin
            m_ready <= 1'b1;
        end else begin
            stall_left <= pick_gap();
            m_ready    <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_little_endian();
        // byte -128, short max, list of end with count 5, empty int array, long min
        byte_q = '{8'h0a, 8'h01, 8'h00, 8'h41,
                   8'h01, 8'h00, 8'h00, 8'h80,
                   8'h02, 8'h00, 8'h00, 8'hff, 8'h7f,
                   8'h09, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00,
                   8'h0b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h04, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
                   8'h00, 8'hff};
        send_buffer();
    endtask

    task automatic test_errors_little_endian();
        byte_q = '{8'h03};
        send_buffer();
        byte_q = '{8'h0a, 8'h00};
        send_buffer();
        // unknown type after its name
        byte_q = '{8'h0a, 8'h00, 8'h00, 8'hfe, 8'h00, 8'h00, 8'h00};
        send_buffer();
        // negative list length
        byte_q = '{8'h0a, 8'h00, 8'h00, 8'h09, 8'h00, 8'h00, 8'h01,
                   8'hff, 8'hff, 8'hff, 8'hff};
        send_buffer();
    endtask

    task automatic test_network();
        // zigzag int -1, over-long int VarInt
        byte_q = '{8'h0a, 8'h00, 8'h03, 8'h00, 8'h01, 8'h00};
        send_buffer();
        byte_q = '{8'h0a, 8'h00, 8'h03, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00};
        send_buffer();
        // negative array length, then unknown list element type
        byte_q = '{8'h0a, 8'h00, 8'h07, 8'h00, 8'h01};
        send_buffer();
        byte_q = '{8'h0a, 8'h00, 8'h09, 8'h00, 8'h0f, 8'h02, 8'h00};
        send_buffer();
    endtask

    task automatic test_stack_full();
        byte_q.delete();
        add_byte(ROOT_BYTE);
        add_byte(8'h00);
        repeat (MAX_DEPTH) begin
            add_byte(8'h0a);
            add_byte(8'h00);
        end
        add_byte(8'h00);
        send_buffer();
    endtask

    task automatic test_random(input int quota);
        int pick;
        int target;
        target = bytes_sent + quota;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                byte_q.delete();
                repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
            end else begin
                build_tree();
                if (pick < 15) byte_q[$urandom_range(0, byte_q.size() - 1)] = 8'($urandom);
                else if (pick < 25) byte_q = byte_q[0:$urandom_range(0, byte_q.size() - 1)];
                else if (pick < 30) repeat (3) add_byte(8'($urandom));
            end
            if ($urandom_range(0, 19) == 0) drain_results();
            gaps_on   = ($urandom_range(0, 4) != 0);
            stalls_on = ($urandom_range(0, 4) != 0);
            send_buffer();
        end
    endtask

    initial begin
        p_fmt = 1'b0;
        rearm_mirror();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_little_endian();
        test_errors_little_endian();
        set_format(1'b1);
        test_network();
        test_stack_full();
        test_random(80);
        set_format(1'b0);
        test_random(80);
        set_format(1'b1);
        test_random(35);

        drain_results();
        $display("Sent %0d buffers, %0d bytes (%0d parsed), checked %0d events in both formats",
                 buffers_sent, bytes_sent, live_bytes, events_seen);
        $display("Covered errors, stack overflow, nested lists, arrays and random stalls");
        if (error_count == 0 && expected_events.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", error_count,
                     expected_events.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/nbt_pkg.sv
design/nbt_frame_ram.sv
design/nbt_evt_out.sv
design/nbt_parse_ctrl.sv
design/nbt_stream_parser.sv
test/testbench.sv
